### src/dbrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbrm_pkg: shared types and constants of the dirty bitmap range marker
// Holds the request and response beat types, the request codes, the
// register width and the default sizes of the mark store.
// ----------------------------------------------------------------------------
package dbrm_pkg;

   // Field widths of the request, response and register.
   localparam int TYPE_W = 3;
   localparam int IDX_W  = 10;
   localparam int LEN_W  = 11;

   // Default store geometry.
   localparam int MAX_BITS_DEFAULT  = 1024;
   localparam int WORD_BITS_DEFAULT = 64;

   // Length in use after reset.
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_SET_RANGE = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_CLR_RANGE = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_TEST_BIT  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_MARK_ALL  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CLEAR_ALL = 3'd4;

   // One request beat.
   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [IDX_W-1:0]  begin_index;
      logic [IDX_W-1:0]  end_index;
   } req_item_type;

   // One response beat.
   typedef struct packed {
      logic ok;
      logic bit_value;
      logic all_clear;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic rd_en;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_word;
   } status_type;

endpackage

`default_nettype wire

### src/dbrm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbrm_ctrl: sequencer of the dirty bitmap range marker
// Takes a request, sweeps every word of the store through the datapath,
// flushes the last write and strobes the response.
// ----------------------------------------------------------------------------
module dbrm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_valid,
   output dbrm_pkg::cmd_type        cmd,
   input  wire dbrm_pkg::status_type status
);
   import dbrm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.rd_en = 1'b1;
            if (status.last_word) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and response strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The response beat comes out while the sequencer is back at rest.
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe outside idle");

   // An accepted request always starts a sweep.
   a_start_sweep: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SWEEP))
      else $error("accepted request did not start a sweep");

   // The flush cycle is always followed by exactly one response beat.
   a_flush_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |=> (rsp_valid_ff && !busy))
      else $error("flush not followed by a response");

endmodule

`default_nettype wire

### src/dbrm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbrm_datapath: mark store and word update of the dirty bitmap marker
// Holds the length register and the word store. Each swept word is read
// into a register, masked against the request and written back, while the
// test bit and the all-clear state are gathered.
// ----------------------------------------------------------------------------
module dbrm_datapath #(
   parameter int MAX_BITS  = dbrm_pkg::MAX_BITS_DEFAULT,
   parameter int WORD_BITS = dbrm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dbrm_pkg::req_item_type     req_item,
   input  wire logic                       csr_wr_en,
   input  wire logic [dbrm_pkg::LEN_W-1:0] csr_wr_data,
   input  wire dbrm_pkg::cmd_type          cmd,
   output dbrm_pkg::status_type            status,
   output dbrm_pkg::rsp_item_type          rsp_item
);
   import dbrm_pkg::*;

   localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int SPAN_W    = $clog2(NUM_WORDS * WORD_BITS + WORD_BITS + 1);
   localparam int CW        = (SPAN_W > LEN_W + 1) ? SPAN_W : LEN_W + 1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SET,
      OP_CLR,
      OP_TEST,
      OP_MARK,
      OP_WIPE
   } op_type;

   // Configuration and latched request.
   logic [LEN_W-1:0] len_cfg_ff;
   logic [CW-1:0]    len_eff;
   logic [CW-1:0]    len_ff;
   logic [CW-1:0]    beg_ext;
   logic [CW-1:0]    end_ext;
   logic [CW-1:0]    beg_ff;
   logic [CW-1:0]    end_ff;
   op_type           op_ff, op_in;
   logic             ok_ff, ok_in;

   // Sweep read side.
   logic [AW-1:0]    rd_addr_ff;
   logic [CW-1:0]    rd_base_ff;

   // Store and registered read.
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] mem_q_ff;
   logic                 vld_q_ff;

   // Write stage.
   logic                 st_valid_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic [CW-1:0]        wr_base_ff;
   logic [WORD_BITS-1:0] word_cur;
   logic [WORD_BITS-1:0] span_mask;
   logic [WORD_BITS-1:0] len_mask;
   logic [WORD_BITS-1:0] test_mask;
   logic [WORD_BITS-1:0] new_word;
   logic                 wr_word;
   logic                 in_use;
   logic                 bit_hit;
   logic                 word_nz;

   // Gathered results.
   logic         bit_ff;
   logic         nz_ff;
   rsp_item_type rsp_ff;

   // Length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         len_cfg_ff <= csr_wr_data;
      end
   end

   // A length above the store size acts as the store size.
   always_comb begin
      len_eff = CW'(len_cfg_ff);
      if (len_eff > CW'(MAX_BITS)) begin
         len_eff = CW'(MAX_BITS);
      end
   end

   assign beg_ext = CW'(req_item.begin_index);
   assign end_ext = CW'(req_item.end_index);

   // Check the request and pick the word operation.
   always_comb begin
      op_in = OP_NONE;
      ok_in = 1'b0;
      unique case (req_item.req_type)
         REQ_SET_RANGE, REQ_CLR_RANGE: begin
            if ((beg_ext <= end_ext) && (end_ext < len_eff)) begin
               ok_in = 1'b1;
               op_in = (req_item.req_type == REQ_SET_RANGE) ? OP_SET : OP_CLR;
            end
         end
         REQ_TEST_BIT: begin
            if (beg_ext < len_eff) begin
               ok_in = 1'b1;
               op_in = OP_TEST;
            end
         end
         REQ_MARK_ALL: begin
            if (len_eff != '0) begin
               ok_in = 1'b1;
               op_in = OP_MARK;
            end
         end
         REQ_CLEAR_ALL: begin
            ok_in = 1'b1;
            op_in = OP_WIPE;
         end
         default: begin
            ok_in = 1'b0;
            op_in = OP_NONE;
         end
      endcase
   end

   // Request latch and read address sweep.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff     <= len_eff;
         beg_ff     <= beg_ext;
         end_ff     <= end_ext;
         op_ff      <= op_in;
         ok_ff      <= ok_in;
         rd_addr_ff <= '0;
         rd_base_ff <= '0;
      end else if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
         rd_base_ff <= rd_base_ff + CW'(WORD_BITS);
      end
   end

   assign status.last_word = (rd_addr_ff == AW'(NUM_WORDS - 1));

   // Store read port, registered.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr_ff];
         vld_q_ff <= valid_ff[rd_addr_ff];
      end
   end

   // Write stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= cmd.rd_en;
      end
      wr_addr_ff <= rd_addr_ff;
      wr_base_ff <= rd_base_ff;
   end

   // A word never written reads as zero.
   assign word_cur = vld_q_ff ? mem_q_ff : '0;
   assign in_use   = (wr_base_ff < len_ff);

   // Per-bit masks from the absolute bit position.
   always_comb begin
      logic [CW-1:0] pos;
      span_mask = '0;
      len_mask  = '0;
      test_mask = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         pos          = wr_base_ff + CW'(j);
         span_mask[j] = (pos >= beg_ff) && (pos <= end_ff);
         len_mask[j]  = (pos < len_ff);
         test_mask[j] = (pos == beg_ff);
      end
   end

   // Word update for the operation in hand.
   always_comb begin
      new_word = word_cur;
      wr_word  = 1'b0;
      unique case (op_ff)
         OP_SET: begin
            new_word = word_cur | span_mask;
            wr_word  = 1'b1;
         end
         OP_CLR: begin
            new_word = word_cur & ~span_mask;
            wr_word  = 1'b1;
         end
         OP_MARK: begin
            if (in_use) begin
               new_word = len_mask;
               wr_word  = 1'b1;
            end
         end
         OP_WIPE: begin
            new_word = '0;
            wr_word  = 1'b1;
         end
         OP_TEST, OP_NONE: begin
            new_word = word_cur;
            wr_word  = 1'b0;
         end
         default: begin
            new_word = word_cur;
            wr_word  = 1'b0;
         end
      endcase
   end

   assign bit_hit = st_valid_ff && (op_ff == OP_TEST) && (|(word_cur & test_mask));
   assign word_nz = st_valid_ff && in_use && (|new_word);

   // Store write port.
   always_ff @(posedge clock) begin
      if (st_valid_ff && wr_word) begin
         mem[wr_addr_ff] <= new_word;
      end
   end

   // Entry valid bits; reset empties the store at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (st_valid_ff && wr_word) begin
         valid_ff[wr_addr_ff] <= 1'b1;
      end
   end

   // Gather the tested bit and the non-empty flag across the sweep.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bit_ff <= 1'b0;
         nz_ff  <= 1'b0;
      end else begin
         bit_ff <= bit_ff | bit_hit;
         nz_ff  <= nz_ff | word_nz;
      end
   end

   // Response register, loaded in the flush cycle.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.ok        <= ok_ff;
         rsp_ff.bit_value <= bit_ff | bit_hit;
         rsp_ff.all_clear <= !(nz_ff | word_nz);
      end
   end

   assign rsp_item = rsp_ff;

   // The write-back never lands on the word being read in the same cycle.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff && cmd.rd_en) |-> (wr_addr_ff != rd_addr_ff))
      else $error("read and write of the same word in one cycle");

   // The flush cycle finishes the last word and reads nothing more.
   a_finish_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (st_valid_ff && !cmd.rd_en))
      else $error("finish without the last write stage");

   // A rejected request leaves the store untouched.
   a_reject_nowrite: assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff && !ok_ff) |-> !wr_word)
      else $error("rejected request wrote the store");

endmodule

`default_nettype wire

### src/dirty_bitmap_range_marker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dirty_bitmap_range_marker: word-stored dirty bitmap with range set/clear
// Sets or clears an inclusive bit range, tests one bit, marks every bit
// below the configured length or wipes the store, and reports ok, the
// tested bit and whether the bitmap in use is empty.
//
//   channel   ports                        handshake
//   request   start, busy, req_item        beat taken when start && !busy
//   response  rsp_valid, rsp_item          one-cycle strobe, no back-pressure
//   register  csr_wr_en, csr_wr_data       written when csr_wr_en is high
//
// Every request sweeps all NUM_WORDS words of the store through one read
// port and one write port, and busy holds off the next request until the
// sweep and its flush are done; the response strobe comes in the cycle
// in which busy falls. Reset is synchronous and empties the store at once
// through per-word valid bits. The receiver cannot stall; a response beat
// is lost if it is not taken in its cycle.
// ----------------------------------------------------------------------------
module dirty_bitmap_range_marker #(
   parameter int MAX_BITS  = dbrm_pkg::MAX_BITS_DEFAULT,
   parameter int WORD_BITS = dbrm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire dbrm_pkg::req_item_type     req_item,
   output logic                            rsp_valid,
   output dbrm_pkg::rsp_item_type          rsp_item,
   input  wire logic                       csr_wr_en,
   input  wire logic [dbrm_pkg::LEN_W-1:0] csr_wr_data
);
   import dbrm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   dbrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Store and word update.
   dbrm_datapath #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

### verif/tb_dirty_bitmap_range_marker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dirty_bitmap_range_marker: self-checking bench for the dirty bitmap
// Walks a short table of directed requests across several lengths in use,
// then runs phases of random requests, each phase under its own length.
// The shadow mark store predicts each response not typed in the table,
// and responses are checked field by field in order as they strobe out.
// ----------------------------------------------------------------------------
module tb_dirty_bitmap_range_marker;
   import dbrm_pkg::*;

   localparam int WB         = WORD_BITS_DEFAULT;
   localparam int MARK_WORDS = MAX_BITS_DEFAULT / WORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PCT = 13;

   // First request code the block does not know; codes up to the field
   // maximum are all unused.
   localparam logic [TYPE_W-1:0] REQ_FIRST_UNUSED = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_LAST_UNUSED  = '1;

   // One directed row: an optional length write, then one request beat,
   // with the response typed in where it is obvious.
   typedef struct packed {
      logic              set_len;
      logic [LEN_W-1:0]  len;
      logic [TYPE_W-1:0] op;
      logic [IDX_W-1:0]  b;
      logic [IDX_W-1:0]  e;
      logic              fixed;
      rsp_item_type      rsp;
   } dir_row_type;

   localparam int DIR_ROWS = 25;
   // Columns: set_len, len, op, begin, end, fixed, {ok, bit, all_clear}.
   localparam dir_row_type DIRECTED [0:DIR_ROWS-1] = '{
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd0,    10'd0,    1'b1, 3'b101},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd1023, 10'd0,    1'b1, 3'b101},
      '{1'b0, 11'd0,    REQ_SET_RANGE,    10'd0,    10'd0,    1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_SET_RANGE,    10'd1023, 10'd1023, 1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_SET_RANGE,    10'd5,    10'd3,    1'b1, 3'b000},
      '{1'b0, 11'd0,    REQ_SET_RANGE,    10'd60,   10'd200,  1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_CLR_RANGE,    10'd63,   10'd64,   1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd64,   10'd0,    1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_CLR_RANGE,    10'd0,    10'd1023, 1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_MARK_ALL,     10'd0,    10'd0,    1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd1023, 10'd1023, 1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_CLEAR_ALL,    10'd1023, 10'd1023, 1'b1, 3'b101},
      '{1'b0, 11'd0,    REQ_FIRST_UNUSED, 10'd0,    10'd0,    1'b1, 3'b001},
      '{1'b0, 11'd0,    REQ_LAST_UNUSED,  10'd1023, 10'd1023, 1'b1, 3'b001},
      '{1'b1, 11'd100,  REQ_SET_RANGE,    10'd50,   10'd100,  1'b1, 3'b001},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd100,  10'd0,    1'b1, 3'b001},
      '{1'b0, 11'd0,    REQ_MARK_ALL,     10'd0,    10'd0,    1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd99,   10'd0,    1'b0, 3'b000},
      '{1'b1, 11'd0,    REQ_SET_RANGE,    10'd0,    10'd0,    1'b1, 3'b001},
      '{1'b0, 11'd0,    REQ_MARK_ALL,     10'd0,    10'd0,    1'b1, 3'b001},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd0,    10'd0,    1'b1, 3'b001},
      '{1'b1, 11'd2047, REQ_SET_RANGE,    10'd1023, 10'd1023, 1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_TEST_BIT,     10'd1023, 10'd0,    1'b0, 3'b000},
      '{1'b1, 11'd1,    REQ_MARK_ALL,     10'd0,    10'd0,    1'b0, 3'b000},
      '{1'b0, 11'd0,    REQ_CLEAR_ALL,    10'd0,    10'd0,    1'b1, 3'b101}
   };

   // Random phases: length in use and number of request beats in each.
   localparam int PHASES = 10;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_item_type     req_item;
   logic             rsp_valid;
   rsp_item_type     rsp_item;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   // Shadow of the mark store and of the length register.
   logic [WB-1:0]    shadow_words [MARK_WORDS];
   logic [LEN_W-1:0] shadow_len;

   rsp_item_type pending_outcomes [$];
   int unsigned  error_count;
   int unsigned  cycle_count;

   dirty_bitmap_range_marker dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Length in use, saturated to the store size.
   function automatic int unsigned effective_len();
      return (shadow_len > MAX_BITS_DEFAULT) ? MAX_BITS_DEFAULT : shadow_len;
   endfunction

   // Applies one request to the shadow store and returns its response.
   function automatic rsp_item_type mark_outcome(input req_item_type r);
      rsp_item_type res;
      int unsigned  len;
      int unsigned  nw;
      int unsigned  b;
      int unsigned  e;
      int unsigned  last;
      int unsigned  i;
      len = effective_len();
      nw  = (len + WB - 1) / WB;
      b   = r.begin_index;
      e   = r.end_index;
      res = '0;
      case (r.req_type)
         REQ_SET_RANGE, REQ_CLR_RANGE: begin
            if (b <= e && e < len) begin
               for (i = b; i <= e; i++)
                  shadow_words[i / WB][i % WB] = (r.req_type == REQ_SET_RANGE);
               res.ok = 1'b1;
            end
         end
         REQ_TEST_BIT: begin
            if (b < len) begin
               res.bit_value = shadow_words[b / WB][b % WB];
               res.ok = 1'b1;
            end
         end
         REQ_MARK_ALL: begin
            // Full words below the last one in use; the last gets only the
            // bits below the length, words beyond it stay as they are.
            if (len > 0) begin
               for (i = 0; i + 1 < nw; i++)
                  shadow_words[i] = '1;
               last = (len - 1) % WB;
               shadow_words[nw - 1] = {WB{1'b1}} >> (WB - 1 - last);
               res.ok = 1'b1;
            end
         end
         REQ_CLEAR_ALL: begin
            for (i = 0; i < MARK_WORDS; i++)
               shadow_words[i] = '0;
            res.ok = 1'b1;
         end
         default: begin
         end
      endcase
      // Only words covered by the length count toward empty.
      res.all_clear = 1'b1;
      for (i = 0; i < nw; i++)
         if (shadow_words[i] != '0)
            res.all_clear = 1'b0;
      return res;
   endfunction

   // Draws one random request, mostly well-formed for the current length.
   function automatic req_item_type random_request();
      req_item_type r;
      int unsigned  len;
      int unsigned  pick;
      int unsigned  e;
      int unsigned  span;
      len  = effective_len();
      pick = $urandom_range(99, 0);
      r.req_type    = TYPE_W'($urandom);
      r.begin_index = IDX_W'($urandom);
      r.end_index   = IDX_W'($urandom);
      if (pick < 60 && len > 0) begin
         // Set or clear a range inside the length, often a short one.
         r.req_type = (pick < 36) ? REQ_SET_RANGE : REQ_CLR_RANGE;
         e = $urandom_range(len - 1, 0);
         if ($urandom_range(1, 0) == 1) begin
            span = $urandom_range(70, 0);
            r.begin_index = (span > e) ? '0 : IDX_W'(e - span);
         end else begin
            r.begin_index = IDX_W'($urandom_range(e, 0));
         end
         r.end_index = IDX_W'(e);
      end else if (pick < 80 && len > 0) begin
         r.req_type    = REQ_TEST_BIT;
         r.begin_index = IDX_W'($urandom_range(len - 1, 0));
      end else if (pick < 84) begin
         r.req_type = REQ_MARK_ALL;
      end else if (pick < 86) begin
         r.req_type = REQ_CLEAR_ALL;
      end else if (pick < 92) begin
         // Inverted range.
         r.req_type = ($urandom_range(1, 0) == 1) ? REQ_SET_RANGE : REQ_CLR_RANGE;
         r.end_index   = IDX_W'($urandom_range(1022, 0));
         r.begin_index = IDX_W'($urandom_range(1023, r.end_index + 1));
      end
      // The rest is noise with every field random.
      return r;
   endfunction

   // Presents one request beat until it is taken, then records its
   // expected response. Starts and ends at a falling edge.
   task automatic send_item(input req_item_type r, input logic fixed,
                            input rsp_item_type fixed_rsp, input bit allow_idle);
      rsp_item_type predicted;
      start    = 1'b1;
      req_item = r;
      do @(posedge clock); while (busy);
      predicted = mark_outcome(r);
      pending_outcomes.push_back(fixed ? fixed_rsp : predicted);
      @(negedge clock);
      if (allow_idle && $urandom_range(99, 0) < IDLE_PCT) begin
         start = 1'b0;
         repeat ($urandom_range(40, 1)) @(negedge clock);
      end
   endtask

   // Holds the sender off until every expected response has arrived.
   task automatic wait_outcomes_drained();
      start = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes the length register while the block is idle.
   task automatic write_length(input logic [LEN_W-1:0] value);
      wait_outcomes_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      shadow_len  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Response checker: every strobed beat must match the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response ok=%b bit=%b clear=%b", $time,
                     rsp_item.ok, rsp_item.bit_value, rsp_item.all_clear);
            error_count++;
         end else begin
            if (rsp_item !== pending_outcomes[0]) begin
               $display("%0t: mismatch, expected ok=%b bit=%b clear=%b, got %b %b %b",
                        $time, pending_outcomes[0].ok, pending_outcomes[0].bit_value,
                        pending_outcomes[0].all_clear, rsp_item.ok, rsp_item.bit_value,
                        rsp_item.all_clear);
               error_count++;
            end
            void'(pending_outcomes.pop_front());
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dirty_bitmap_range_marker test failed");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      int unsigned      phase_len [PHASES];
      int unsigned      phase_items [PHASES];
      int               p;
      int               n;
      int               i;
      logic [LEN_W-1:0] len_value;

      error_count = 0;
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      shadow_len  = LEN_RESET;
      for (i = 0; i < MARK_WORDS; i++)
         shadow_words[i] = '0;

      phase_len   = '{1024, 2047, 64, 65, 1, 0, 1023, 0, 0, 1024};
      phase_items = '{70, 70, 60, 60, 50, 80, 80, 20, 80, 80};
      phase_len[5] = $urandom_range(1023, 2);
      phase_len[8] = $urandom_range(1024, 1);

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed table.
      for (i = 0; i < DIR_ROWS; i++) begin
         if (DIRECTED[i].set_len)
            write_length(DIRECTED[i].len);
         send_item('{DIRECTED[i].op, DIRECTED[i].b, DIRECTED[i].e},
                   DIRECTED[i].fixed, DIRECTED[i].rsp, 1'b1);
      end

      // Random phases, one length each; the phase with index 3 runs without idling.
      for (p = 0; p < PHASES; p++) begin
         len_value = LEN_W'(phase_len[p]);
         write_length(len_value);
         for (n = 0; n < phase_items[p]; n++)
            send_item(random_request(), 1'b0, '0, p != 3);
      end

      wait_outcomes_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("dirty_bitmap_range_marker test passed");
      end else begin
         $display("dirty_bitmap_range_marker test failed");
      end
      $finish;
   end

endmodule

### filelist.f
src/dbrm_pkg.sv
src/dbrm_ctrl.sv
src/dbrm_datapath.sv
src/dirty_bitmap_range_marker.sv
verif/tb_dirty_bitmap_range_marker.sv
